// ----- hw/rtl/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Farthest free slot allocator package
// Item codes, register indexes, fixed field widths and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Fixed field widths of the ports.
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int CFG_W    = 7;
  localparam int GAP_W    = 7;
  localparam int CFG_IDX_W = 1;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEAT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 1'b1;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] SEAT_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] MIN_GAP_RST    = 7'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cnt_clr;     // restart the slot counter
    logic latch_req;   // capture the slot count and clear the scan state
    logic sweep_wr;    // write a free slot at the counter and advance
    logic mark_wr;     // mark the input slot occupied
    logic issue;       // read the slot at the counter and advance
    logic final_cand;  // judge the candidate past the last slot
    logic res_zero;    // present an all-zero result
    logic res_req;     // present the request result and occupy on grant
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // counter is at the last built slot
    logic scan_last;   // counter is at the last slot in use
  } dp_status_t;

endpackage

// ----- hw/rtl/ffsa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ffsa_datapath.sv -----
// ----------------------------------------------------------------------------
// Farthest free slot allocator datapath
// Holds the configuration, the occupancy memory, the slot counter, the
// single pass gap scan and the result register.
// ----------------------------------------------------------------------------
module ffsa_datapath #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffsa_pkg::dp_cmd_t             cmd,
  output ffsa_pkg::dp_status_t          status,
  input  logic [ffsa_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic                          cfg_we,
  input  logic [ffsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffsa_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [ffsa_pkg::SLOT_W-1:0]   out_chosen_slot,
  output logic [ffsa_pkg::GAP_W-1:0]    out_best_gap
);

  import ffsa_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  // Configuration registers.
  logic [CFG_W-1:0] seat_count_r, min_gap_r;

  // Counter and scan state.
  logic [AW-1:0] cnt_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] nm1_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_pos_r;
  logic          have_occ_r;
  logic [AW-1:0] last_r;
  logic          best_vld_r;
  logic [CW-1:0] best_gap_r;
  logic [AW-1:0] best_idx_r;

  // Result registers.
  logic             out_valid_r, out_granted_r;
  logic [SLOT_W-1:0] out_chosen_r;
  logic [GAP_W-1:0]  out_best_r;

  // Memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  // Candidate logic.
  logic          cand_en;
  logic [AW-1:0] cand_idx;
  logic [CW-1:0] cand_gap;
  logic [AW-1:0] diff;
  logic [AW-1:0] half;
  logic          upd_best;
  logic          grant;
  logic          slot_ok;
  logic [31:0]   sc_ext;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seat_count_r <= SEAT_COUNT_RST;
      min_gap_r    <= MIN_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEAT_COUNT: seat_count_r <= cfg_wdata;
        REG_MIN_GAP:    min_gap_r    <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Clamp the slot count to the built range.
  always_comb begin
    sc_ext = 32'(seat_count_r);
    if (sc_ext == 32'd0) begin
      n_nxt = CW'(1);
    end else if (sc_ext > 32'(MAX_SLOTS)) begin
      n_nxt = CW'(MAX_SLOTS);
    end else begin
      n_nxt = CW'(sc_ext);
    end
  end

  // Status toward the controller.
  assign status.sweep_last = (cnt_r == AW'(MAX_SLOTS - 1));
  assign status.scan_last  = (cnt_r == nm1_r);

  // Candidate for the best slot. An occupied slot closes a run of free
  // slots, best at slot 0 for the first run and else halfway, rounded
  // toward the start. The final candidate covers the trailing free run.
  always_comb begin
    diff     = '0;
    half     = '0;
    cand_idx = '0;
    cand_gap = '0;
    if (cmd.final_cand) begin
      cand_en = 1'b1;
      if (!have_occ_r) begin
        cand_gap = n_r;
      end else begin
        diff     = nm1_r - last_r;
        cand_idx = nm1_r;
        cand_gap = CW'(diff);
      end
    end else begin
      cand_en = rd_vld_r & ram_rdata;
      if (!have_occ_r) begin
        cand_gap = CW'(rd_pos_r);
      end else begin
        diff     = rd_pos_r - last_r;
        half     = diff >> 1;
        cand_idx = last_r + half;
        cand_gap = CW'(half);
      end
    end
    upd_best = cand_en & (!best_vld_r | (cand_gap > best_gap_r));
  end

  // Grant decision and mark range check.
  assign grant   = (32'(best_gap_r) >= 32'(min_gap_r));
  assign slot_ok = (32'(in_slot_index) < 32'(MAX_SLOTS));

  // Counter and scan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      have_occ_r <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.sweep_wr || cmd.issue) begin
        cnt_r <= cnt_r + AW'(1);
      end
      rd_vld_r <= cmd.issue;
      if (cmd.latch_req) begin
        have_occ_r <= 1'b0;
        best_vld_r <= 1'b0;
      end else begin
        if (rd_vld_r && ram_rdata) begin
          have_occ_r <= 1'b1;
        end
        if (upd_best) begin
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  // Scan payload registers.
  always_ff @(posedge clk) begin
    rd_pos_r <= cnt_r;
    if (cmd.latch_req) begin
      n_r   <= n_nxt;
      nm1_r <= AW'(n_nxt - CW'(1));
    end
    if (rd_vld_r && ram_rdata) begin
      last_r <= rd_pos_r;
    end
    if (upd_best) begin
      best_gap_r <= cand_gap;
      best_idx_r <= cand_idx;
    end
  end

  // Memory write select.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = 1'b0;
    priority if (cmd.sweep_wr) begin
      ram_we = 1'b1;
    end else if (cmd.mark_wr) begin
      ram_we    = slot_ok;
      ram_waddr = AW'(in_slot_index);
      ram_wdata = 1'b1;
    end else if (cmd.res_req) begin
      ram_we    = grant;
      ram_waddr = best_idx_r;
      ram_wdata = 1'b1;
    end
  end

  ffsa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_SLOTS)
  ) u_occ_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r),
    .rdata(ram_rdata)
  );

  // Result register: each result is shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_zero | cmd.res_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_req) begin
      out_granted_r <= grant;
      out_chosen_r  <= grant ? SLOT_W'(best_idx_r) : '0;
      out_best_r    <= GAP_W'(best_gap_r);
    end else begin
      out_granted_r <= 1'b0;
      out_chosen_r  <= '0;
      out_best_r    <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_chosen_r;
  assign out_best_gap    = out_best_r;

endmodule

// ----- hw/rtl/ffsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Farthest free slot allocator controller
// Sequences the clearing sweep, the mark write and the request scan.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffsa_pkg::KIND_W-1:0] in_kind,
  output logic                        busy,
  output ffsa_pkg::dp_cmd_t           cmd,
  input  ffsa_pkg::dp_status_t        status
);

  import ffsa_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_GRANT = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (in_kind)
            KIND_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_CLEAR;
            end
            KIND_MARK: begin
              cmd.mark_wr  = 1'b1;
              cmd.res_zero = 1'b1;
            end
            KIND_REQUEST: begin
              cmd.cnt_clr   = 1'b1;
              cmd.latch_req = 1'b1;
              state_nxt     = S_SCAN;
            end
            default: begin
              cmd.res_zero = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd.final_cand = 1'b1;
        state_nxt      = S_GRANT;
      end
      S_GRANT: begin
        cmd.res_req = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/farthest_free_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// Farthest free slot allocator
// Keeps a slot occupancy map and places requests on the free slot that is
// farthest from any occupied slot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and every item gives
// exactly one result, shown on the out_ ports for one cycle with out_valid
// high; the receiver cannot stall, so it must take each transfer as it comes.
// After reset the block clears its occupancy memory with busy high. A mark
// item, or an item of the unused kind, gives its result in the next cycle
// and the block is ready again at once. A clear item sweeps the occupancy
// memory one slot a cycle with busy high; its result is registered as the
// last slot is written. A placement request reads the n slots in use one a
// cycle from the occupancy memory, then closes the scan and decides in the
// drain, final and grant states with busy high; the result is registered
// from the grant state. The user must write configuration only while busy
// is low and no result is pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module farthest_free_slot_allocator #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ffsa_pkg::KIND_W-1:0]    in_kind,
  input  logic [ffsa_pkg::SLOT_W-1:0]    in_slot_index,
  output logic                           out_valid,
  output logic                           out_granted,
  output logic [ffsa_pkg::SLOT_W-1:0]    out_chosen_slot,
  output logic [ffsa_pkg::GAP_W-1:0]     out_best_gap,
  input  logic                           cfg_we,
  input  logic [ffsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffsa_pkg::CFG_W-1:0]     cfg_wdata
);

  import ffsa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller.
  ffsa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_kind(in_kind),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // Datapath.
  ffsa_datapath #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_slot_index  (in_slot_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_granted    (out_granted),
    .out_chosen_slot(out_chosen_slot),
    .out_best_gap   (out_best_gap)
  );

endmodule
